FILE: design/ddo_pkg.sv
// Package: shared types, constants and tables for the odometry block.
package ddo_pkg;

    localparam int CORDIC_STEPS = 28;
    localparam int CNT_W = $clog2(CORDIC_STEPS);
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [33:0] ONE_Q30 = 34'sd1073741824;
    localparam logic signed [33:0] TWO_PI_Q16 = 34'sd411775;
    localparam logic signed [33:0] US_PER_S = 34'sd1000000;
    localparam int DIV_W = 56;
    localparam logic [31:0] DIST_RESET = 32'd155690;
    localparam logic [31:0] TURN_RESET = 32'd143645;

    typedef enum logic [0:0] {
        REG_DIST = 1'b0,
        REG_TURN = 1'b1
    } t_reg;

    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_MUL_D, OP_MUL_STEP, OP_MUL_DX, OP_MUL_DY,
        OP_MUL_HI, OP_MUL_LO, OP_UPDATE, OP_VMUL, OP_VDIV_START, OP_VWAIT,
        OP_CORD2, OP_PUBLISH
    } t_op;

    typedef enum logic [3:0] {
        ST_IDLE, ST_CORD1, ST_MD, ST_MSTEP, ST_MDX, ST_MDY, ST_MHI, ST_MLO,
        ST_UPD, ST_VMUL, ST_VDIV0, ST_VDIV, ST_CORD2, ST_CWAIT2, ST_DONE
    } t_state;

    typedef struct packed {
        t_op        op;
        logic [1:0] sel;
    } t_cmd;

    typedef struct packed {
        logic cord_done;
        logic div_done;
        logic out_full;
        logic zero_dt;
    } t_sts;

    // arctangent of 2^-i in binary angle units
    function automatic logic [31:0] atan_bam(input logic [CNT_W-1:0] i);
        logic [31:0] v;
        unique case (i)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000029;
            5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A;
            5'd27: v = 32'h00000005;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] sat35(input logic signed [34:0] v);
        logic signed [31:0] r;
        if (v > 35'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -35'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Q1.30 to Q1.15, rounded and clamped
    function automatic logic signed [15:0] q15(input logic signed [31:0] v);
        logic signed [32:0] t;
        logic signed [17:0] s;
        logic signed [15:0] r;
        t = {v[31], v} + 33'sd16384;
        s = t[32:15];
        if (s > 18'sd32767) begin
            r = 16'sh7FFF;
        end else if (s < -18'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = s[15:0];
        end
        return r;
    endfunction

endpackage

FILE: design/ddo_if.sv
// Interfaces: input and result channels of the odometry block.
interface ddo_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] left_ticks;
    logic signed [15:0] right_ticks;
    logic [31:0]        stamp_us;
    modport source (output valid, left_ticks, right_ticks, stamp_us, input ready);
    modport sink (input valid, left_ticks, right_ticks, stamp_us, output ready);
endinterface

interface ddo_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [31:0]        heading;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] turn_rate;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
    logic               zero_interval;
    modport source (output valid, pos_x, pos_y, heading, vel_x, vel_y, turn_rate,
                    quat_z, quat_w, zero_interval, input ready);
    modport sink (input valid, pos_x, pos_y, heading, vel_x, vel_y, turn_rate,
                  quat_z, quat_w, zero_interval, output ready);
endinterface

FILE: design/ddo_cordic.sv
// Iterative CORDIC: cosine and sine of a binary angle, Q1.30, one step per cycle.
module ddo_cordic
    import ddo_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [31:0]        i_angle,
    output logic               o_done,
    output logic signed [31:0] o_cos,
    output logic signed [31:0] o_sin
);
    logic                    r_busy, r_fin, r_done, r_flip;
    logic [CNT_W-1:0]        r_cnt;
    logic signed [33:0]      r_x, r_y, r_z;
    logic signed [31:0]      r_cos, r_sin;
    logic                    flip;
    logic [31:0]             fold;
    logic [31:0]             sum_q;
    logic signed [33:0]      xs, ys, at, xf, yf;

    assign sum_q = i_angle + 32'h40000000;
    assign flip  = sum_q[31];
    assign fold  = flip ? (i_angle ^ 32'h80000000) : i_angle;
    assign xs    = r_x >>> r_cnt;
    assign ys    = r_y >>> r_cnt;
    assign at    = {2'b00, atan_bam(r_cnt)};
    assign xf    = r_flip ? -r_x : r_x;
    assign yf    = r_flip ? -r_y : r_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_fin;
            r_fin  <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CNT_W'(CORDIC_STEPS - 1)) begin
                r_busy <= 1'b0;
                r_fin  <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= CORDIC_GAIN;
            r_y    <= '0;
            r_z    <= {{2{fold[31]}}, fold};
            r_flip <= flip;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (!r_z[33]) begin
                r_x <= r_x - ys;
                r_y <= r_y + xs;
                r_z <= r_z - at;
            end else begin
                r_x <= r_x + ys;
                r_y <= r_y - xs;
                r_z <= r_z + at;
            end
        end
        if (r_fin) begin
            r_cos <= (xf > ONE_Q30) ? ONE_Q30[31:0] : (xf < -ONE_Q30) ? -ONE_Q30[31:0]
                                                                   : xf[31:0];
            r_sin <= (yf > ONE_Q30) ? ONE_Q30[31:0] : (yf < -ONE_Q30) ? -ONE_Q30[31:0]
                                                                   : yf[31:0];
        end
    end

    assign o_done = r_done;
    assign o_cos  = r_cos;
    assign o_sin  = r_sin;
endmodule

FILE: design/ddo_div.sv
// Restoring divider: unsigned quotient, one bit per cycle.
module ddo_div
    import ddo_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DIV_W-1:0] i_dividend,
    input  logic [31:0]      i_divisor,
    output logic             o_done,
    output logic [DIV_W-1:0] o_quot
);
    localparam int QC_W = $clog2(DIV_W + 1);

    logic             r_busy, r_done;
    logic [QC_W-1:0]  r_cnt;
    logic [DIV_W-1:0] r_q;
    logic [31:0]      r_rem, r_div;
    logic [32:0]      trial;
    logic             ge;

    assign trial = {r_rem, r_q[DIV_W-1]};
    assign ge    = trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == QC_W'(DIV_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            r_rem <= ge ? 32'(trial - {1'b0, r_div}) : trial[31:0];
            r_q   <= {r_q[DIV_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

FILE: design/ddo_dp.sv
// Datapath: config registers, pose state, shared multiplier, CORDIC, divider, output register.
module ddo_dp
    import ddo_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    ddo_in_if.sink      in_ch,
    ddo_out_if.source   out_ch
);
    logic [31:0]        r_dist, r_turn, r_head, r_last, r_dt;
    logic signed [31:0] r_acc_x, r_acc_y;
    logic signed [15:0] r_l, r_r;
    logic signed [69:0] r_prod;
    logic signed [33:0] r_d16, r_dx, r_dy;
    logic signed [49:0] r_step;
    logic [47:0]        r_mag;
    logic [43:0]        r_hip;
    logic [36:0]        r_r16m;
    logic               r_r16neg, r_vneg, r_out_valid;
    logic signed [31:0] r_vel [3];
    logic signed [31:0] r_o_x, r_o_y, r_o_vx, r_o_vy, r_o_wz;
    logic [31:0]        r_o_head;
    logic signed [15:0] r_o_qz, r_o_qw;
    logic               r_o_zero;

    logic signed [35:0] mul_a;
    logic signed [33:0] mul_b;
    logic signed [16:0] sum_t, diff_t;
    logic signed [69:0] rnd16, rnd30;
    logic [43:0]        lo_t;
    logic [44:0]        r16_sum;
    logic signed [33:0] vn;
    logic [34:0]        vmag;
    logic               cord_start, cord_done, div_start, div_done;
    logic signed [31:0] cos_v, sin_v, vsat;
    logic [DIV_W-1:0]   quot;

    assign sum_t  = 17'(r_r) + 17'(r_l);
    assign diff_t = 17'(r_r) - 17'(r_l);
    assign rnd16  = r_prod + 70'sd32768;
    assign rnd30  = r_prod + 70'sd536870912;
    assign lo_t   = r_prod[43:0] + 44'h80000000;
    assign r16_sum = {1'b0, r_hip} + {21'b0, lo_t[43:24]};

    always_comb begin
        unique case (i_cmd.sel)
            2'd0:    vn = r_dx;
            2'd1:    vn = r_dy;
            default: vn = r_r16neg ? -$signed({1'b0, r_r16m[32:0]})
                                   : $signed({1'b0, r_r16m[32:0]});
        endcase
    end
    // the turn rate magnitude can exceed 33 bits; take it unsigned here
    assign vmag = (i_cmd.sel == 2'd2) ? r_r16m[34:0]
                : (vn[33] ? 35'(-vn) : 35'(vn));

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.op)
            OP_MUL_D:    begin mul_a = 36'(sum_t);  mul_b = {2'b00, r_dist}; end
            OP_MUL_STEP: begin mul_a = 36'(diff_t); mul_b = {2'b00, r_turn}; end
            OP_MUL_DX:   begin mul_a = 36'(r_d16);  mul_b = 34'(cos_v); end
            OP_MUL_DY:   begin mul_a = 36'(r_d16);  mul_b = 34'(sin_v); end
            OP_MUL_HI:   begin mul_a = {12'b0, r_mag[47:24]}; mul_b = TWO_PI_Q16; end
            OP_MUL_LO:   begin mul_a = {12'b0, r_mag[23:0]};  mul_b = TWO_PI_Q16; end
            OP_VMUL:     begin mul_a = {1'b0, vmag}; mul_b = US_PER_S; end
            default:     begin mul_a = '0; mul_b = '0; end
        endcase
    end

    assign cord_start = (i_cmd.op == OP_LOAD) || (i_cmd.op == OP_CORD2);
    assign div_start  = (i_cmd.op == OP_VDIV_START);

    ddo_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cord_start),
        .i_angle ((i_cmd.op == OP_LOAD) ? r_head : {1'b0, r_head[31:1]}),
        .o_done  (cord_done),
        .o_cos   (cos_v),
        .o_sin   (sin_v)
    );

    ddo_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_prod[DIV_W-1:0] + {{(DIV_W-31){1'b0}}, r_dt[31:1]}),
        .i_divisor  (r_dt),
        .o_done     (div_done),
        .o_quot     (quot)
    );

    always_comb begin
        if (!r_vneg) begin
            vsat = (quot > DIV_W'(32'h7FFFFFFF)) ? 32'sh7FFFFFFF : quot[31:0];
        end else begin
            vsat = (quot > DIV_W'(32'h80000000)) ? 32'sh80000000 : -quot[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dist      <= DIST_RESET;
            r_turn      <= TURN_RESET;
            r_acc_x     <= '0;
            r_acc_y     <= '0;
            r_head      <= '0;
            r_last      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_reg'(i_cfg_idx))
                    REG_DIST: r_dist <= i_cfg_data;
                    REG_TURN: r_turn <= i_cfg_data;
                    default:  ;
                endcase
            end
            if (i_cmd.op == OP_LOAD) begin
                r_last <= in_ch.stamp_us;
            end
            if (i_cmd.op == OP_UPDATE) begin
                r_acc_x <= sat35(35'(r_acc_x) + 35'(r_dx));
                r_acc_y <= sat35(35'(r_acc_y) + 35'(r_dy));
                r_head  <= r_head + r_step[31:0];
            end
            if (i_cmd.op == OP_PUBLISH) begin
                r_out_valid <= 1'b1;
            end else if (out_ch.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        case (i_cmd.op)
            OP_LOAD: begin
                r_l      <= in_ch.left_ticks;
                r_r      <= in_ch.right_ticks;
                r_dt     <= in_ch.stamp_us - r_last;
                r_vel[0] <= '0;
                r_vel[1] <= '0;
                r_vel[2] <= '0;
            end
            OP_MUL_STEP: r_d16 <= rnd16[49:16];
            OP_MUL_DX:   r_step <= r_prod[49:0];
            OP_MUL_DY: begin
                r_dx  <= rnd30[63:30];
                r_mag <= r_step[49] ? 48'(-r_step) : r_step[47:0];
            end
            OP_MUL_HI:   r_dy <= rnd30[63:30];
            OP_MUL_LO:   r_hip <= r_prod[43:0];
            OP_UPDATE: begin
                r_r16m   <= r16_sum[44:8];
                r_r16neg <= r_step[49];
            end
            // turn rate sign comes from the step, its magnitude may not fit vn
            OP_VMUL:     r_vneg <= (i_cmd.sel == 2'd2) ? r_r16neg : vn[33];
            OP_VWAIT:    if (div_done) r_vel[i_cmd.sel] <= vsat;
            OP_PUBLISH: begin
                r_o_x    <= r_acc_x;
                r_o_y    <= r_acc_y;
                r_o_head <= r_head;
                r_o_vx   <= r_vel[0];
                r_o_vy   <= r_vel[1];
                r_o_wz   <= r_vel[2];
                r_o_qz   <= q15(sin_v);
                r_o_qw   <= q15(cos_v);
                r_o_zero <= (r_dt == '0);
            end
            default: ;
        endcase
    end

    assign o_sts.cord_done = cord_done;
    assign o_sts.div_done  = div_done;
    assign o_sts.out_full  = r_out_valid;
    assign o_sts.zero_dt   = (r_dt == '0);

    assign out_ch.valid         = r_out_valid;
    assign out_ch.pos_x         = r_o_x;
    assign out_ch.pos_y         = r_o_y;
    assign out_ch.heading       = r_o_head;
    assign out_ch.vel_x         = r_o_vx;
    assign out_ch.vel_y         = r_o_vy;
    assign out_ch.turn_rate     = r_o_wz;
    assign out_ch.quat_z        = r_o_qz;
    assign out_ch.quat_w        = r_o_qw;
    assign out_ch.zero_interval = r_o_zero;
endmodule

FILE: design/ddo_ctrl.sv
// Controller: sequences the datapath through one item.
module ddo_ctrl
    import ddo_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    t_state     r_state, n_state;
    logic [1:0] r_sel, n_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_sel   <= '0;
        end else begin
            r_state <= n_state;
            r_sel   <= n_sel;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_sel      = r_sel;
        o_cmd.op   = OP_NONE;
        o_cmd.sel  = r_sel;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = ST_CORD1;
                end
            end
            ST_CORD1: if (i_sts.cord_done) n_state = ST_MD;
            ST_MD:    begin o_cmd.op = OP_MUL_D;    n_state = ST_MSTEP; end
            ST_MSTEP: begin o_cmd.op = OP_MUL_STEP; n_state = ST_MDX;   end
            ST_MDX:   begin o_cmd.op = OP_MUL_DX;   n_state = ST_MDY;   end
            ST_MDY:   begin o_cmd.op = OP_MUL_DY;   n_state = ST_MHI;   end
            ST_MHI:   begin o_cmd.op = OP_MUL_HI;   n_state = ST_MLO;   end
            ST_MLO:   begin o_cmd.op = OP_MUL_LO;   n_state = ST_UPD;   end
            ST_UPD: begin
                o_cmd.op = OP_UPDATE;
                n_sel    = '0;
                n_state  = i_sts.zero_dt ? ST_CORD2 : ST_VMUL;
            end
            ST_VMUL:  begin o_cmd.op = OP_VMUL;       n_state = ST_VDIV0; end
            ST_VDIV0: begin o_cmd.op = OP_VDIV_START; n_state = ST_VDIV;  end
            ST_VDIV: begin
                o_cmd.op = OP_VWAIT;
                if (i_sts.div_done) begin
                    if (r_sel == 2'd2) begin
                        n_state = ST_CORD2;
                    end else begin
                        n_sel   = r_sel + 1'b1;
                        n_state = ST_VMUL;
                    end
                end
            end
            ST_CORD2:  begin o_cmd.op = OP_CORD2; n_state = ST_CWAIT2; end
            ST_CWAIT2: if (i_sts.cord_done) n_state = ST_DONE;
            ST_DONE: begin
                // hold until the previous result has been transferred
                if (!i_sts.out_full) begin
                    o_cmd.op = OP_PUBLISH;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    a_load_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == ST_CORD1))
        else $error("accepted item did not start the CORDIC wait");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == OP_PUBLISH) |-> !i_sts.out_full)
        else $error("result register overwritten before transfer");
    a_div_in_place: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.div_done |-> (r_state == ST_VDIV))
        else $error("divider finished outside the velocity step");
endmodule

FILE: design/differential_drive_odometry.sv
// Top level: differential drive odometry, controller plus datapath.
//  channel   | dir | handshake      | payload
//  i_in      | in  | valid/ready    | left_ticks, right_ticks, stamp_us
//  o_res     | out | valid/ready    | pose, velocities, quaternion, zero_interval
//  i_cfg_*   | in  | write enable   | 0 dist_per_tick, 1 turn_per_tick
// One item runs as: load, two CORDIC passes, the multiply/update steps, publish,
// and for a nonzero interval three velocity steps, each with a divider pass.
// Sequential: one item in flight; the result register lets the next item enter
// while a result still waits, and publish stalls until the old result transfers.
// Reset is synchronous, active low; no clearing pass.
module differential_drive_odometry
    import ddo_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    ddo_in_if.sink      i_in,
    ddo_out_if.source   o_res
);
    t_cmd cmd;
    t_sts sts;

    ddo_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    ddo_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .in_ch      (i_in),
        .out_ch     (o_res)
    );
endmodule
